@@ sv/hcds_pkg.sv @@
// Shared types and constants for the heightfield cell store.
`timescale 1ns / 1ps
package hcds_pkg;
   localparam logic [2:0] ACT_LOAD   = 3'd0;
   localparam logic [2:0] ACT_DEFORM = 3'd1;
   localparam logic [2:0] ACT_READ   = 3'd2;
   localparam logic [2:0] ACT_SETMAT = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   localparam logic [2:0] REG_DEPTH = 3'd0;
   localparam logic [2:0] REG_RAISE = 3'd1;
   localparam logic [2:0] REG_MINH  = 3'd2;
   localparam logic [2:0] REG_MAXH  = 3'd3;
   localparam logic [2:0] REG_GW    = 3'd4;
   localparam logic [2:0] REG_GD    = 3'd5;

   localparam logic [11:0] SCALE_ONE = 12'd256;

   typedef struct packed {
      logic [2:0]         action;
      logic               inb;
      logic [7:0]         x;
      logic [7:0]         z;
      logic signed [15:0] value;
      logic               respect;
      logic [8:0]         hardness;
      logic [11:0]        scale;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_MUL, ST_SCALE, ST_CALC, ST_OUT
   } state_type;
endpackage

@@ sv/hcds_front.sv @@
// Front end: accepts items, checks bounds and queues classified commands.
`timescale 1ns / 1ps
module hcds_front #(
   parameter int GRID_X = 256,
   parameter int GRID_Z = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [2:0]         action,
   input  logic [7:0]         cell_x,
   input  logic [7:0]         cell_z,
   input  logic [15:0]        value,
   input  logic               respect,
   input  logic [8:0]         hardness,
   input  logic [11:0]        disp_scale,
   input  logic [8:0]         grid_width,
   input  logic [8:0]         grid_depth,
   output logic               q_valid,
   input  logic               q_ready,
   output hcds_pkg::cmd_type  q_cmd
);
   // two-entry queue
   hcds_pkg::cmd_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   hcds_pkg::cmd_type c;
   logic push, pop;

   always_comb begin
      c.action   = action;
      c.x        = cell_x;
      c.z        = cell_z;
      c.value    = $signed(value);
      c.respect  = respect;
      c.hardness = hardness;
      c.scale    = disp_scale;
      c.inb      = ({1'b0, cell_x} < grid_width) && ({1'b0, cell_z} < grid_depth)
                   && (32'(cell_x) < GRID_X) && (32'(cell_z) < GRID_Z);
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = mem_ff[rp_ff];
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= c;
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !in_ready) else $error("accept while full");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !q_valid) else $error("pop while empty");
`endif
endmodule

@@ sv/hcds_back.sv @@
// Back end: per-cell read-modify-write over the cell memories.
`timescale 1ns / 1ps
module hcds_back #(
   parameter int GRID_X = 256,
   parameter int GRID_Z = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  hcds_pkg::cmd_type  q_cmd,
   input  logic [14:0]        max_depth,
   input  logic [14:0]        max_raise,
   input  logic [15:0]        min_height,
   input  logic [15:0]        max_height,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [135:0]       out_data,
   output logic               busy
);
   localparam int CELLS = GRID_X * GRID_Z;
   localparam int AW = $clog2(CELLS);

   // Memories clear by a sweep after reset.
   logic [15:0] hmem [CELLS];
   logic [15:0] omem [CELLS];
   logic [15:0] dmem [CELLS];
   logic [8:0]  kmem [CELLS];
   logic [11:0] smem [CELLS];

   hcds_pkg::state_type st_ff, st_in;
   hcds_pkg::cmd_type cmd_ff;
   logic [AW:0] clr_ff;
   logic        clearing;
   logic signed [15:0] rh_ff, ro_ff, rd_ff;
   logic [8:0]  rk_ff;
   logic [11:0] rs_ff;
   logic [20:0] prod_ff, prod_in;
   logic signed [37:0] sprod;
   logic signed [21:0] dl_ff, dl_in, sumd, nd;
   logic signed [17:0] sumh, nh, lh, hv;
   logic signed [15:0] nh_ff, no_ff, nd_ff;
   logic signed [15:0] lv, ld;
   logic        dirty_ff;
   logic [7:0]  bminx_ff, bminz_ff, bmaxx_ff, bmaxz_ff;
   logic [15:0] peak_ff;
   logic [31:0] cnt_ff;
   logic [AW-1:0] addr, caddr_ff;
   logic [15:0] ad;
   logic        wr;

   assign clearing = !clr_ff[AW];
   assign addr = AW'(int'(q_cmd.z) * GRID_X + int'(q_cmd.x));
   assign busy = (st_ff != hcds_pkg::ST_IDLE);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         hcds_pkg::ST_IDLE:  if (q_valid && !clearing) st_in = hcds_pkg::ST_READ;
         hcds_pkg::ST_READ:  st_in = hcds_pkg::ST_MUL;
         hcds_pkg::ST_MUL:   st_in = hcds_pkg::ST_SCALE;
         hcds_pkg::ST_SCALE: st_in = hcds_pkg::ST_CALC;
         hcds_pkg::ST_CALC:  st_in = hcds_pkg::ST_OUT;
         hcds_pkg::ST_OUT:   if (out_ready) st_in = hcds_pkg::ST_IDLE;
         default: st_in = hcds_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      q_ready = 1'b0; out_valid = 1'b0;
      case (st_ff)
         hcds_pkg::ST_IDLE: q_ready = !clearing;
         hcds_pkg::ST_OUT:  out_valid = 1'b1;
         default: ;
      endcase
   end

   // material factor scale*(256-hardness), then value times that factor when respect is set
   assign prod_in = 21'(rs_ff) * (21'd256 - 21'(rk_ff));
   assign sprod = 38'($signed(cmd_ff.value)) * $signed({1'b0, prod_ff}) + 38'sd32768;
   assign dl_in = cmd_ff.respect ? 22'(sprod >>> 16) : 22'(cmd_ff.value);

   always_comb begin
      lh = 18'($signed(min_height));
      hv = 18'($signed(max_height));
      sumd = 22'(rd_ff) + dl_ff;
      nd = sumd;
      if (nd > $signed({7'd0, max_raise})) nd = $signed({7'd0, max_raise});
      if (nd < -$signed({7'd0, max_depth})) nd = -$signed({7'd0, max_depth});
      sumh = 18'(ro_ff) + 18'(nd);
      nh = sumh;
      if (nh > hv) nh = hv;
      if (nh < lh) nh = lh;
      ad = nd[21] ? 16'(-nd) : 16'(nd);
      lv = (cmd_ff.value > $signed(max_height)) ? $signed(max_height) : cmd_ff.value;
      ld = (lv < $signed(min_height)) ? $signed(min_height) : lv;
   end

   assign wr = (st_ff == hcds_pkg::ST_CALC) && cmd_ff.inb;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= hcds_pkg::ST_IDLE; clr_ff <= '0;
         dirty_ff <= 1'b0; bminx_ff <= 8'hFF; bminz_ff <= 8'hFF;
         bmaxx_ff <= 8'h00; bmaxz_ff <= 8'h00; peak_ff <= '0; cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (st_ff == hcds_pkg::ST_CALC) begin
            if (cmd_ff.action == hcds_pkg::ACT_DEFORM && cmd_ff.inb) begin
               if (cnt_ff != '1) cnt_ff <= cnt_ff + 1'b1;
               if (ad > peak_ff) peak_ff <= ad;
               dirty_ff <= 1'b1;
               if (cmd_ff.x < bminx_ff) bminx_ff <= cmd_ff.x;
               if (cmd_ff.z < bminz_ff) bminz_ff <= cmd_ff.z;
               if (cmd_ff.x > bmaxx_ff) bmaxx_ff <= cmd_ff.x;
               if (cmd_ff.z > bmaxz_ff) bmaxz_ff <= cmd_ff.z;
            end else if (cmd_ff.action == hcds_pkg::ACT_CLEAR) begin
               dirty_ff <= 1'b0; bminx_ff <= 8'hFF; bminz_ff <= 8'hFF;
               bmaxx_ff <= 8'h00; bmaxz_ff <= 8'h00;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) begin
         cmd_ff <= q_cmd; caddr_ff <= addr;
      end
      if (st_ff == hcds_pkg::ST_READ) begin
         rh_ff <= hmem[caddr_ff]; ro_ff <= omem[caddr_ff];
         rd_ff <= dmem[caddr_ff]; rk_ff <= kmem[caddr_ff];
         rs_ff <= smem[caddr_ff];
      end
      if (st_ff == hcds_pkg::ST_MUL) prod_ff <= prod_in;
      if (st_ff == hcds_pkg::ST_SCALE) dl_ff <= dl_in;
      if (st_ff == hcds_pkg::ST_CALC) begin
         if (!cmd_ff.inb) begin
            nh_ff <= '0; no_ff <= '0; nd_ff <= '0;
         end else if (cmd_ff.action == hcds_pkg::ACT_LOAD) begin
            nh_ff <= ld; no_ff <= ld; nd_ff <= '0;
         end else if (cmd_ff.action == hcds_pkg::ACT_DEFORM) begin
            nh_ff <= 16'(nh); no_ff <= ro_ff; nd_ff <= 16'(nd);
         end else begin
            nh_ff <= rh_ff; no_ff <= ro_ff; nd_ff <= rd_ff;
         end
      end
      if (clearing) begin
         hmem[clr_ff[AW-1:0]] <= '0; omem[clr_ff[AW-1:0]] <= '0;
         dmem[clr_ff[AW-1:0]] <= '0; kmem[clr_ff[AW-1:0]] <= '0;
         smem[clr_ff[AW-1:0]] <= hcds_pkg::SCALE_ONE;
      end else if (wr) begin
         case (cmd_ff.action)
            hcds_pkg::ACT_LOAD: begin
               hmem[caddr_ff] <= ld;
               omem[caddr_ff] <= ld;
               dmem[caddr_ff] <= '0;
            end
            hcds_pkg::ACT_DEFORM: begin
               hmem[caddr_ff] <= 16'(nh); dmem[caddr_ff] <= 16'(nd);
            end
            hcds_pkg::ACT_SETMAT: begin
               kmem[caddr_ff] <= (cmd_ff.hardness > 9'd256) ? 9'd256 : cmd_ff.hardness;
               smem[caddr_ff] <= cmd_ff.scale;
            end
            default: ;
         endcase
      end
   end

   assign out_data = {6'd0, cnt_ff, peak_ff, bmaxz_ff, bmaxx_ff, bminz_ff, bminx_ff,
                      dirty_ff, nd_ff, no_ff, nh_ff, cmd_ff.inb};

`ifndef SYNTHESIS
   a_noq: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_ready) else $error("item taken during clear");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
   a_box: assert property (@(posedge clock) disable iff (reset)
      dirty_ff |-> (bminx_ff <= bmaxx_ff)) else $error("dirty box inverted");
`endif
endmodule

@@ sv/heightfield_cell_deform_store.sv @@
// Top level of the heightfield cell deform store.
// Usage:
//  req_ channel carries one action on one cell per item; rsp_ channel returns
//  one result item per request, in order. Config registers sit on the APB
//  port at byte addresses 4*i; the user must write them only while the block
//  idles, which the block itself does not enforce. The back end takes one
//  item at a time: memory read, material multiply, delta scaling, compute
//  and write-back, then output. The next item is taken the cycle after the
//  result leaves, so no new item enters before the last result is out.
//  The front queue holds two items, so up to two requests are accepted while a
//  result waits for rsp_tready; a stalled receiver holds the result steady.
//  After reset the cell memories are cleared by a sweep over all cells,
//  during which the back end takes no item, though the front queue still
//  accepts up to two requests; registers take their reset values at once.
`timescale 1ns / 1ps
module heightfield_cell_deform_store #(
   parameter int GRID_X = 256,
   parameter int GRID_Z = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[2:0], cell_x[10:3], cell_z[18:11], value[34:19], respect[35],
   // hardness[44:36], disp_scale[56:45]
   input  logic [63:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // in_bounds[0], height[16:1], original_height[32:17], cell_delta[48:33],
   // dirty[49], dirty_min_x, dirty_min_z, dirty_max_x, dirty_max_z,
   // peak_depth, modified_count
   output logic [135:0] rsp_tdata,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   logic [14:0] depth_ff, raise_ff;
   logic [15:0] minh_ff, maxh_ff;
   logic [8:0]  gw_ff, gd_ff;
   logic q_valid, q_ready, busy;
   hcds_pkg::cmd_type q_cmd;
   logic [2:0] ridx;

   assign pready = 1'b1;
   assign ridx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= 15'h7FFF; raise_ff <= 15'h7FFF;
         minh_ff <= 16'h8000; maxh_ff <= 16'h7FFF;
         gw_ff <= 9'd256; gd_ff <= 9'd256;
      end else if (psel && penable && pwrite) begin
         case (ridx)
            hcds_pkg::REG_DEPTH: depth_ff <= pwdata[14:0];
            hcds_pkg::REG_RAISE: raise_ff <= pwdata[14:0];
            hcds_pkg::REG_MINH:  minh_ff <= pwdata[15:0];
            hcds_pkg::REG_MAXH:  maxh_ff <= pwdata[15:0];
            hcds_pkg::REG_GW:    gw_ff <= pwdata[8:0];
            hcds_pkg::REG_GD:    gd_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         hcds_pkg::REG_DEPTH: prdata = {17'd0, depth_ff};
         hcds_pkg::REG_RAISE: prdata = {17'd0, raise_ff};
         hcds_pkg::REG_MINH:  prdata = {16'd0, minh_ff};
         hcds_pkg::REG_MAXH:  prdata = {16'd0, maxh_ff};
         hcds_pkg::REG_GW:    prdata = {23'd0, gw_ff};
         hcds_pkg::REG_GD:    prdata = {23'd0, gd_ff};
         default:             prdata = 32'd0;
      endcase
   end

   hcds_front #(.GRID_X(GRID_X), .GRID_Z(GRID_Z)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .action(req_tdata[2:0]), .cell_x(req_tdata[10:3]), .cell_z(req_tdata[18:11]),
      .value(req_tdata[34:19]), .respect(req_tdata[35]),
      .hardness(req_tdata[44:36]), .disp_scale(req_tdata[56:45]),
      .grid_width(gw_ff), .grid_depth(gd_ff),
      .q_valid, .q_ready, .q_cmd);

   hcds_back #(.GRID_X(GRID_X), .GRID_Z(GRID_Z)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd,
      .max_depth(depth_ff), .max_raise(raise_ff),
      .min_height(minh_ff), .max_height(maxh_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata),
      .busy);

`ifndef SYNTHESIS
   a_cfg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> busy) else $error("result without work");
   a_rdy: assert property (@(posedge clock) pready) else $error("pready low");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("result moved");
`endif
endmodule
